### sv/lrufr_pkg.sv
// ----------------------------------------------------------------------------
// lrufr_pkg: shared types for the LRU frame replacement list
// Holds the sequencer states and the command and result records that pass
// between the list core and the stream wrapper.
// ----------------------------------------------------------------------------
package lrufr_pkg;

	// Operation codes carried on the input tuser bit.
	localparam logic OP_TOUCH  = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_APPEND,
		ST_REPORT
	} lrufr_state_t;

	typedef struct packed {
		logic       op;
		logic [5:0] frame;
	} lrufr_cmd_t;

	typedef struct packed {
		logic       was_listed;
		logic [6:0] listed_count;
		logic [5:0] victim_frame;
		logic       victim_valid;
	} lrufr_result_t;

endpackage

### sv/lru_frame_replacement.sv
// ----------------------------------------------------------------------------
// lru_frame_replacement: LRU replacement list over evictable frames
// Stream wrapper around the recency list core, with a registered result
// stage so that a waiting result does not hold back the next command.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit up)                          tuser
//  s_axis    in         frame[5:0], zero pad to 8 bits              op
//  m_axis    out        victim_valid, victim_frame[5:0],            none
//                       listed_count[6:0], was_listed, zero pad
//
// In the core, the transfer cycle of a command issues the reads of the flag
// and link memories, the next cycle unlinks, the next appends, and the last
// hands the result to the output register. Unlink and append are separate
// steps since each link memory has a single write port, which both need.
// After reset the core clears every entry of the flag memory before it
// accepts the first command. A stalled result sits in the output register
// while the core already takes the next command; the core waits in its
// report step only if that register is still full.
//
module lru_frame_replacement
	import lrufr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // frame[5:0], pad
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // victim_valid, victim_frame, listed_count,
	                                     // was_listed, pad
);

	lrufr_cmd_t    cmd;
	lrufr_result_t res;
	logic          res_valid;
	logic          res_ready;

	logic          out_valid_q;
	lrufr_result_t out_q;

	assign cmd.op    = s_axis_tuser;
	assign cmd.frame = s_axis_tdata[5:0];

	lrufr_core #(.NUM_FRAMES(NUM_FRAMES)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register takes a new result when it is empty or when its
	// current result leaves in the same cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.was_listed, out_q.listed_count,
		out_q.victim_frame, out_q.victim_valid};

endmodule

### sv/lrufr_ram.sv
// ----------------------------------------------------------------------------
// lrufr_ram: simple dual-port memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lrufr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/lrufr_core.sv
// ----------------------------------------------------------------------------
// lrufr_core: recency list sequencer
// Holds the doubly linked list in two link memories and a membership flag
// memory, and walks each command through read, unlink, append and report steps.
// ----------------------------------------------------------------------------
module lrufr_core
	import lrufr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  lrufr_cmd_t    cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output lrufr_result_t res
);

	localparam int IDX_W = $clog2(NUM_FRAMES);
	localparam int CNT_W = $clog2(NUM_FRAMES + 1);

	lrufr_state_t state_q, state_d;

	logic             op_q;
	logic [IDX_W-1:0] frame_q;
	logic             fvalid_q;
	logic             was_q, was_d;
	logic [IDX_W-1:0] oldest_q, oldest_d;
	logic [IDX_W-1:0] newest_q, newest_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] clr_q;

	// Memory ports.
	logic             ol_we, nw_we, fl_we;
	logic [IDX_W-1:0] ol_waddr, nw_waddr, fl_waddr;
	logic [IDX_W-1:0] ol_wdata, nw_wdata;
	logic             fl_wdata;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] ol_rdata, nw_rdata;
	logic             fl_rdata;

	logic [12:0] cnt_ext;
	logic [11:0] old_ext;

	assign rd_addr = IDX_W'(cmd.frame);

	lrufr_ram #(.DEPTH(NUM_FRAMES), .WIDTH(IDX_W)) u_older (
		.clk   (clk),
		.we    (ol_we),
		.waddr (ol_waddr),
		.wdata (ol_wdata),
		.raddr (rd_addr),
		.rdata (ol_rdata)
	);

	lrufr_ram #(.DEPTH(NUM_FRAMES), .WIDTH(IDX_W)) u_newer (
		.clk   (clk),
		.we    (nw_we),
		.waddr (nw_waddr),
		.wdata (nw_wdata),
		.raddr (rd_addr),
		.rdata (nw_rdata)
	);

	lrufr_ram #(.DEPTH(NUM_FRAMES), .WIDTH(1)) u_flag (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.raddr (rd_addr),
		.rdata (fl_rdata)
	);

	always_comb begin
		state_d   = state_q;
		was_d     = was_q;
		oldest_d  = oldest_q;
		newest_d  = newest_q;
		count_d   = count_q;
		ol_we     = 1'b0;
		ol_waddr  = frame_q;
		ol_wdata  = newest_q;
		nw_we     = 1'b0;
		nw_waddr  = newest_q;
		nw_wdata  = frame_q;
		fl_we     = 1'b0;
		fl_waddr  = frame_q;
		fl_wdata  = 1'b0;
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				fl_we    = 1'b1;
				fl_waddr = clr_q;
				fl_wdata = 1'b0;
				if (clr_q == IDX_W'(NUM_FRAMES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// Unlink the frame if it is in the list.
				was_d = fvalid_q & fl_rdata;
				if (fvalid_q && fl_rdata) begin
					if (count_q <= CNT_W'(1)) begin
						count_d = '0;
					end else begin
						if (frame_q == oldest_q) begin
							oldest_d = nw_rdata;
						end else if (frame_q == newest_q) begin
							newest_d = ol_rdata;
						end else begin
							nw_we    = (32'(ol_rdata) < NUM_FRAMES);
							nw_waddr = ol_rdata;
							nw_wdata = nw_rdata;
							ol_we    = (32'(nw_rdata) < NUM_FRAMES);
							ol_waddr = nw_rdata;
							ol_wdata = ol_rdata;
						end
						count_d = count_q - CNT_W'(1);
					end
				end
				state_d = ST_APPEND;
			end
			ST_APPEND: begin
				if (fvalid_q) begin
					fl_we    = 1'b1;
					fl_waddr = frame_q;
					fl_wdata = (op_q == OP_TOUCH);
					if (op_q == OP_TOUCH) begin
						if (count_q == '0) begin
							oldest_d = frame_q;
						end else begin
							nw_we    = (32'(newest_q) < NUM_FRAMES);
							nw_waddr = newest_q;
							nw_wdata = frame_q;
							ol_we    = 1'b1;
							ol_waddr = frame_q;
							ol_wdata = newest_q;
						end
						newest_d = frame_q;
						count_d  = count_q + CNT_W'(1);
					end
				end
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			oldest_q <= '0;
			newest_q <= '0;
			count_q  <= '0;
			was_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			oldest_q <= oldest_d;
			newest_q <= newest_d;
			count_q  <= count_d;
			was_q    <= was_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			op_q     <= cmd.op;
			frame_q  <= IDX_W'(cmd.frame);
			fvalid_q <= (32'(cmd.frame) < NUM_FRAMES);
		end
	end

	assign cnt_ext = 13'(count_q);
	assign old_ext = 12'(oldest_q);

	always_comb begin
		res.victim_valid = (count_q != '0);
		res.victim_frame = (count_q != '0) ? old_ext[5:0] : 6'd0;
		res.listed_count = cnt_ext[6:0];
		res.was_listed   = was_q;
	end

endmodule
